// File: rtl/gate_open_close_controller_defines.svh
`ifndef GATE_OPEN_CLOSE_CONTROLLER_DEFINES_SVH
`define GATE_OPEN_CLOSE_CONTROLLER_DEFINES_SVH

// check a property at every edge outside reset
`define GOCC_ASSERT(name, clk, rst, prop) \
   name: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("gocc assertion failed");

// check a property at every edge, reset included
`define GOCC_ASSERT_ALWAYS(name, clk, prop) \
   name: assert property (@(posedge clk) prop) \
      else $error("gocc assertion failed");

`endif

// File: rtl/gocc_pkg.sv
package gocc_pkg;

   typedef enum logic [1:0] {
      MODE_CLOSED  = 2'd0,
      MODE_OPENING = 2'd1,
      MODE_OPEN    = 2'd2,
      MODE_CLOSING = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      KIND_TICK  = 2'd0,
      KIND_OPEN  = 2'd1,
      KIND_CLOSE = 2'd2,
      KIND_HOLD  = 2'd3
   } kind_type;

   localparam logic signed [7:0] OPEN_FULL    = 8'sd100;
   localparam logic signed [7:0] OPEN_SHUT    = 8'sd0;
   localparam logic signed [7:0] BAR_LIMIT    = 8'sd110;
   localparam logic signed [7:0] BAR_QUARTER  = 8'sd25;
   localparam logic signed [7:0] BAR_HALF     = 8'sd50;
   localparam logic signed [7:0] BAR_3QUARTER = 8'sd75;
   localparam logic [6:0]        WAIT_FULL    = 7'd100;
   localparam logic [6:0]        WAIT_MAX     = 7'd115;
   localparam logic [2:0]        BAR_EMPTY    = 3'd4;

   localparam int RSP_WIDTH = 24;

   // floor(x/255) as (x + 1 + (x >> 8)) >> 8, exact for these ranges
   function automatic logic [3:0] travel_step(input logic [7:0] s);
      logic [9:0] x;
      logic [9:0] sum;
      x   = {1'b0, s, 1'b0} + {2'b00, s} + 10'd254;
      sum = x + 10'd1 + {8'd0, x[9:8]};
      return 4'd8 - {2'b00, sum[9:8]};
   endfunction

   function automatic logic [4:0] wait_step(input logic [7:0] s);
      logic [11:0] x;
      logic [11:0] sum;
      x   = {1'b0, s, 3'b000} + {2'b00, s, 2'b00} + {4'd0, s} + 12'd254;
      sum = x + 12'd1 + {8'd0, x[11:8]};
      return 5'd16 - {1'b0, sum[11:8]};
   endfunction

endpackage

// File: rtl/gate_open_close_controller.sv
// Gate controller, one result transfer per input transfer.
// Each accepted result is registered, in the skid register if the result register
// is stalled. Throughput: one item per cycle while the skid register is empty; a
// two-entry output buffer (result register plus skid register) lets req_tready
// stay high while one result waits. Reset (synchronous): gate closed, amounts 0,
// bar at four dashes, lamp off, output buffer empty.
module gate_open_close_controller
   import gocc_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [15:0]          req_tdata,  // travel_speed_sample, wait_speed_sample
   input  logic [1:0]           req_tuser,  // kind
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [RSP_WIDTH-1:0] rsp_tdata   // gate_state, led_on, dashes_shown,
                                            // open_amount, wait_amount, zero pad
);

   mode_type          mode_ff, mode_in;
   logic signed [7:0] opening_ff, opening_in;
   logic [6:0]        waiting_ff, waiting_in;
   logic [2:0]        bar_ff, bar_in;
   logic              lamp_ff, lamp_in;

   logic                 out_valid_ff, out_valid_in;
   logic [RSP_WIDTH-1:0] out_data_ff, out_data_in;
   logic                 skid_valid_ff, skid_valid_in;
   logic [RSP_WIDTH-1:0] skid_data_ff, skid_data_in;

   logic                 accept;
   logic                 pop;
   kind_type             kind;
   logic [3:0]           travel;
   logic [4:0]           wait_inc;
   logic [RSP_WIDTH-1:0] result;

   assign req_tready = !skid_valid_ff;
   assign accept     = req_tvalid && req_tready;
   assign pop        = out_valid_ff && rsp_tready;
   assign kind       = kind_type'(req_tuser);
   assign travel     = travel_step(req_tdata[7:0]);
   assign wait_inc   = wait_step(req_tdata[15:8]);

   always_comb begin
      mode_in    = mode_ff;
      opening_in = opening_ff;
      waiting_in = waiting_ff;
      lamp_in    = lamp_ff;
      bar_in     = bar_ff;
      unique case (kind)
         KIND_TICK: begin
            if (mode_ff != MODE_CLOSED) begin
               lamp_in = ~lamp_ff;
            end
            unique case (mode_ff)
               MODE_OPENING: begin
                  if (opening_ff >= OPEN_FULL) begin
                     mode_in = MODE_OPEN;
                  end else begin
                     opening_in = opening_ff + $signed({4'b0000, travel});
                  end
               end
               MODE_OPEN: begin
                  if (waiting_ff >= WAIT_FULL) begin
                     waiting_in = 7'd0;
                     mode_in    = MODE_CLOSING;
                  end else begin
                     waiting_in = waiting_ff + {2'b00, wait_inc};
                  end
               end
               MODE_CLOSING: begin
                  if (opening_ff <= OPEN_SHUT) begin
                     mode_in = MODE_CLOSED;
                  end else begin
                     opening_in = opening_ff - $signed({4'b0000, travel});
                  end
               end
               MODE_CLOSED: begin
               end
            endcase
         end
         KIND_OPEN: begin
            if (mode_ff == MODE_CLOSED || mode_ff == MODE_CLOSING) begin
               mode_in = MODE_OPENING;
            end
         end
         KIND_CLOSE: begin
            if (mode_ff == MODE_OPEN) begin
               waiting_in = WAIT_FULL;
            end
         end
         KIND_HOLD: begin
            if (mode_ff == MODE_OPEN) begin
               waiting_in = 7'd0;
            end else if (mode_ff == MODE_CLOSING) begin
               mode_in = MODE_OPENING;
            end
         end
      endcase

      if (mode_in == MODE_CLOSED) begin
         lamp_in = 1'b0;
         bar_in  = BAR_EMPTY;
      end else if (opening_in >= OPEN_SHUT && opening_in <= BAR_LIMIT) begin
         priority if (opening_in < BAR_QUARTER) begin
            bar_in = 3'd4;
         end else if (opening_in < BAR_HALF) begin
            bar_in = 3'd3;
         end else if (opening_in < BAR_3QUARTER) begin
            bar_in = 3'd2;
         end else if (opening_in < OPEN_FULL) begin
            bar_in = 3'd1;
         end else begin
            bar_in = 3'd0;
         end
      end
   end

   assign result = {3'b000, waiting_in, opening_in, bar_in, lamp_in, mode_in};

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= MODE_CLOSED;
         opening_ff <= 8'sd0;
         waiting_ff <= 7'd0;
         bar_ff     <= BAR_EMPTY;
         lamp_ff    <= 1'b0;
      end else if (accept) begin
         mode_ff    <= mode_in;
         opening_ff <= opening_in;
         waiting_ff <= waiting_in;
         bar_ff     <= bar_in;
         lamp_ff    <= lamp_in;
      end
   end

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (skid_valid_ff) begin
         if (pop) begin
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end
      end else if (accept) begin
         if (!out_valid_ff || pop) begin
            out_valid_in = 1'b1;
            out_data_in  = result;
         end else begin
            skid_valid_in = 1'b1;
            skid_data_in  = result;
         end
      end else if (pop) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

endmodule

// File: rtl/gocc_checker.sv
`include "gate_open_close_controller_defines.svh"

module gocc_checker
   import gocc_pkg::*;
(
   input logic                 clock,
   input logic                 reset,
   input logic                 req_tready,
   input logic                 rsp_tvalid,
   input logic                 rsp_tready,
   input logic [RSP_WIDTH-1:0] rsp_tdata
);

   logic       rsp_stall;
   logic       rsp_closed;
   logic [1:0] rsp_state;
   logic       rsp_lamp;
   logic [2:0] rsp_bar;
   logic [6:0] rsp_wait;

   assign rsp_state  = rsp_tdata[1:0];
   assign rsp_lamp   = rsp_tdata[2];
   assign rsp_bar    = rsp_tdata[5:3];
   assign rsp_wait   = rsp_tdata[20:14];
   assign rsp_stall  = rsp_tvalid && !rsp_tready;
   assign rsp_closed = rsp_tvalid && rsp_state == MODE_CLOSED;

   `GOCC_ASSERT(a_rsp_hold, clock, reset, rsp_stall |=> rsp_tvalid && $stable(rsp_tdata))
   `GOCC_ASSERT(a_stall_only_when_full, clock, reset, !req_tready |-> rsp_tvalid)
   `GOCC_ASSERT(a_closed_display, clock, reset, rsp_closed |-> !rsp_lamp && rsp_bar == BAR_EMPTY)
   `GOCC_ASSERT(a_range, clock, reset, rsp_tvalid |-> rsp_wait <= WAIT_MAX && rsp_bar <= BAR_EMPTY)
   `GOCC_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rsp_tvalid && req_tready)

endmodule

bind gate_open_close_controller gocc_checker u_gocc_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

// File: verif/tb.sv
module tb;
   import gocc_pkg::*;

   localparam int RANDOM_ITEMS = 400;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int PRINT_LIMIT  = 40;

   // result layout, lowest bits first: state, lamp, dashes, amount, wait, pad
   typedef struct packed {
      logic [2:0]        pad;
      logic [6:0]        wt;
      logic signed [7:0] amt;
      logic [2:0]        dash;
      logic              led;
      mode_type          st;
   } gate_view_type;

   typedef struct packed {
      kind_type      kind;
      logic [7:0]    ts;
      logic [7:0]    ws;
      logic [7:0]    reps;
      logic          chk;
      gate_view_type view;
   } script_row_type;

   localparam gate_view_type NO_VIEW = '0;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [15:0]          req_tdata = '0;  // travel_speed_sample, wait_speed_sample
   logic [1:0]           req_tuser = KIND_TICK;  // kind
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [RSP_WIDTH-1:0] rsp_tdata;  // gate_state, led_on, dashes_shown,
                                     // open_amount, wait_amount, zero pad

   logic          pin_on = 1'b0;
   gate_view_type pin_view = NO_VIEW;

   mode_type   g_mode;
   int         g_amount;
   int         g_wait;
   logic [2:0] g_bar;
   logic       g_lamp;

   gate_view_type expected_views[$];
   int         idle_pct = 0;
   int         stall_pct = 0;
   int         mismatch_count = 0;
   int         accepted_items = 0;
   int         closed_ticks = 0;
   int         checked_results = 0;
   int         negative_results = 0;
   int         kind_counts[4] = '{0, 0, 0, 0};
   int         cycles = 0;

   gate_open_close_controller dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d results outstanding", cycles,
                  expected_views.size());
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   task automatic report_mismatch(input string what, input int got, input int want);
      mismatch_count++;
      if (mismatch_count <= PRINT_LIMIT)
         $display("Mismatch at result %0d: %s got %0d, want %0d", checked_results, what,
                  got, want);
   endtask

   task automatic step_gate(input kind_type k, input logic [7:0] ts, input logic [7:0] ws,
                            output gate_view_type v);
      int tstep;
      int wstep;
      tstep = 8 - (3 * int'(ts) + 254) / 255;
      wstep = 16 - (13 * int'(ws) + 254) / 255;
      case (k)
         KIND_TICK: begin
            if (g_mode != MODE_CLOSED) begin
               g_lamp = ~g_lamp;
               case (g_mode)
                  MODE_OPENING: begin
                     if (g_amount >= OPEN_FULL) g_mode = MODE_OPEN;
                     else g_amount += tstep;
                  end
                  MODE_OPEN: begin
                     if (g_wait >= int'(WAIT_FULL)) begin
                        g_wait = 0;
                        g_mode = MODE_CLOSING;
                     end else begin
                        g_wait += wstep;
                     end
                  end
                  default: begin
                     if (g_amount <= OPEN_SHUT) g_mode = MODE_CLOSED;
                     else g_amount -= tstep;
                  end
               endcase
            end
         end
         KIND_OPEN: begin
            if (g_mode == MODE_CLOSED || g_mode == MODE_CLOSING) g_mode = MODE_OPENING;
         end
         KIND_CLOSE: begin
            if (g_mode == MODE_OPEN) g_wait = int'(WAIT_FULL);
         end
         default: begin
            if (g_mode == MODE_OPEN) g_wait = 0;
            else if (g_mode == MODE_CLOSING) g_mode = MODE_OPENING;
         end
      endcase
      if (g_mode == MODE_CLOSED) begin
         g_lamp = 1'b0;
         g_bar  = BAR_EMPTY;
      end else if (g_amount >= 0 && g_amount <= BAR_LIMIT) begin
         if (g_amount < BAR_QUARTER) g_bar = 3'd4;
         else if (g_amount < BAR_HALF) g_bar = 3'd3;
         else if (g_amount < BAR_3QUARTER) g_bar = 3'd2;
         else if (g_amount < OPEN_FULL) g_bar = 3'd1;
         else g_bar = 3'd0;
      end
      v.pad  = '0;
      v.wt   = g_wait[6:0];
      v.amt  = g_amount[7:0];
      v.dash = g_bar;
      v.led  = g_lamp;
      v.st   = g_mode;
   endtask

   always @(posedge clock) begin : accept_mon
      gate_view_type v;
      kind_type      k;
      if (reset) begin
         g_mode   = MODE_CLOSED;
         g_amount = 0;
         g_wait   = 0;
         g_bar    = BAR_EMPTY;
         g_lamp   = 1'b0;
      end else if (req_tvalid && req_tready) begin
         k = kind_type'(req_tuser);
         if (k == KIND_TICK && g_mode == MODE_CLOSED) closed_ticks++;
         kind_counts[req_tuser]++;
         accepted_items++;
         step_gate(k, req_tdata[7:0], req_tdata[15:8], v);
         expected_views.push_back(pin_on ? pin_view : v);
      end
   end

   always @(posedge clock) begin
      rsp_tready <= reset ? 1'b0 : ($urandom_range(99) >= stall_pct);
   end

   always @(posedge clock) begin : result_mon
      gate_view_type got;
      gate_view_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = gate_view_type'(rsp_tdata);
         if (expected_views.size() == 0) begin
            report_mismatch("unexpected result transfer, state", got.st, -1);
         end else begin
            want = expected_views.pop_front();
            if (got.st !== want.st) report_mismatch("gate_state", got.st, want.st);
            if (got.led !== want.led) report_mismatch("led_on", got.led, want.led);
            if (got.dash !== want.dash) report_mismatch("dashes_shown", got.dash, want.dash);
            if (got.amt !== want.amt) report_mismatch("open_amount", got.amt, want.amt);
            if (got.wt !== want.wt) report_mismatch("wait_amount", got.wt, want.wt);
            if (got.pad !== want.pad) report_mismatch("pad", got.pad, want.pad);
            if (want.amt < 0) negative_results++;
         end
         checked_results++;
      end
   end

   task automatic send_item(input kind_type k, input logic [7:0] ts, input logic [7:0] ws,
                            input logic chk, input gate_view_type view);
      while ($urandom_range(99) < idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= k;
      req_tdata  <= {ws, ts};
      pin_on     <= chk;
      pin_view   <= view;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic drain_results();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (expected_views.size() != 0) @(posedge clock);
   endtask

   function automatic logic [7:0] pick_sample();
      int r;
      r = $urandom_range(99);
      if (r < 15) return 8'd0;
      if (r < 30) return 8'd255;
      return 8'($urandom_range(255));
   endfunction

   script_row_type script[] = '{
      // tick and buttons while closed
      '{KIND_TICK,  8'd0,   8'd0,   8'd1,  1'b1,
        '{pad: 3'd0, wt: 7'd0, amt: 8'sd0, dash: 3'd4, led: 1'b0, st: MODE_CLOSED}},
      '{KIND_HOLD,  8'd255, 8'd255, 8'd1,  1'b0, NO_VIEW},
      '{KIND_CLOSE, 8'd0,   8'd0,   8'd1,  1'b0, NO_VIEW},
      '{KIND_OPEN,  8'd255, 8'd0,   8'd1,  1'b1,
        '{pad: 3'd0, wt: 7'd0, amt: 8'sd0, dash: 3'd4, led: 1'b0, st: MODE_OPENING}},
      // travel at largest then smallest step
      '{KIND_TICK,  8'd0,   8'd0,   8'd12, 1'b0, NO_VIEW},
      '{KIND_HOLD,  8'd0,   8'd0,   8'd1,  1'b0, NO_VIEW},
      '{KIND_CLOSE, 8'd0,   8'd0,   8'd1,  1'b0, NO_VIEW},
      '{KIND_TICK,  8'd255, 8'd255, 8'd1,  1'b0, NO_VIEW},
      '{KIND_TICK,  8'd0,   8'd0,   8'd1,  1'b0, NO_VIEW},
      // wait steps, hold, open ignored, close-now
      '{KIND_TICK,  8'd0,   8'd0,   8'd1,  1'b0, NO_VIEW},
      '{KIND_TICK,  8'd0,   8'd255, 8'd1,  1'b0, NO_VIEW},
      '{KIND_HOLD,  8'd0,   8'd0,   8'd1,  1'b0, NO_VIEW},
      '{KIND_OPEN,  8'd0,   8'd0,   8'd1,  1'b0, NO_VIEW},
      '{KIND_CLOSE, 8'd0,   8'd0,   8'd1,  1'b0, NO_VIEW},
      '{KIND_TICK,  8'd0,   8'd0,   8'd1,  1'b0, NO_VIEW},
      // reopen by hold while closing
      '{KIND_TICK,  8'd0,   8'd0,   8'd2,  1'b0, NO_VIEW},
      '{KIND_HOLD,  8'd0,   8'd0,   8'd1,  1'b0, NO_VIEW},
      '{KIND_TICK,  8'd0,   8'd0,   8'd2,  1'b0, NO_VIEW},
      '{KIND_TICK,  8'd0,   8'd0,   8'd1,  1'b0, NO_VIEW},
      '{KIND_CLOSE, 8'd0,   8'd0,   8'd1,  1'b0, NO_VIEW},
      '{KIND_TICK,  8'd0,   8'd0,   8'd1,  1'b0, NO_VIEW},
      // reopen by open button while closing
      '{KIND_OPEN,  8'd0,   8'd0,   8'd1,  1'b0, NO_VIEW},
      '{KIND_TICK,  8'd0,   8'd0,   8'd1,  1'b0, NO_VIEW},
      '{KIND_CLOSE, 8'd0,   8'd0,   8'd1,  1'b0, NO_VIEW},
      '{KIND_TICK,  8'd0,   8'd0,   8'd1,  1'b0, NO_VIEW},
      // close past zero, amount goes negative and stays there while closed
      '{KIND_TICK,  8'd0,   8'd0,   8'd13, 1'b0, NO_VIEW},
      '{KIND_TICK,  8'd0,   8'd0,   8'd1,  1'b1,
        '{pad: 3'd0, wt: 7'd0, amt: -8'sd3, dash: 3'd4, led: 1'b0, st: MODE_CLOSED}},
      '{KIND_TICK,  8'd0,   8'd0,   8'd1,  1'b0, NO_VIEW},
      '{KIND_OPEN,  8'd0,   8'd0,   8'd1,  1'b0, NO_VIEW},
      '{KIND_TICK,  8'd255, 8'd255, 8'd1,  1'b0, NO_VIEW},
      '{KIND_TICK,  8'd128, 8'd128, 8'd1,  1'b0, NO_VIEW}
   };

   initial begin
      int         phase_idle[4];
      int         phase_stall[4];
      int         r;
      kind_type   k;
      phase_idle  = '{0, 65, 0, 12};
      phase_stall = '{0, 0, 65, 12};
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (script[i]) begin
         repeat (script[i].reps)
            send_item(script[i].kind, script[i].ts, script[i].ws, script[i].chk,
                      script[i].view);
      end

      for (int ph = 0; ph < 4; ph++) begin
         // hold off until every result is back
         drain_results();
         idle_pct  = phase_idle[ph];
         stall_pct = phase_stall[ph];
         for (int n = 0; n < RANDOM_ITEMS / 4; n++) begin
            r = $urandom_range(99);
            if (r < 76) k = KIND_TICK;
            else if (r < 84) k = KIND_OPEN;
            else if (r < 90) k = KIND_CLOSE;
            else k = KIND_HOLD;
            send_item(k, pick_sample(), pick_sample(), 1'b0, NO_VIEW);
         end
      end

      idle_pct = 0;
      drain_results();
      stall_pct = 0;
      repeat (8) @(posedge clock);
      if (expected_views.size() != 0)
         report_mismatch("results left outstanding", expected_views.size(), 0);

      $display("Covered %0d input transfers (%0d ticks while closed), %0d results checked",
               accepted_items, closed_ticks, checked_results);
      $display("Kinds tick/open/close/hold %0d/%0d/%0d/%0d, %0d results with negative amount",
               kind_counts[0], kind_counts[1], kind_counts[2], kind_counts[3],
               negative_results);
      if (mismatch_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
